FILE: design/sgemm_bias_relu_top_assert.svh
// Assertion macros for the matrix engine.
// Expects clk and arst_n to exist in the module that includes this header.
`ifndef SGEMM_BIAS_RELU_TOP_ASSERT_SVH
`define SGEMM_BIAS_RELU_TOP_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define SBR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define SBR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/sbr_pkg.sv
// Shared types and constants of the matrix engine.
// No dependencies; used by sbr_fma and sgemm_bias_relu_top.
`default_nettype none

package sbr_pkg;

	// Command codes of an input item.
	localparam logic [1:0] CMD_LOAD_A    = 2'd0;
	localparam logic [1:0] CMD_LOAD_B    = 2'd1;
	localparam logic [1:0] CMD_LOAD_BIAS = 2'd2;
	localparam logic [1:0] CMD_EMIT      = 2'd3;

	// Configuration register indexes and port widths.
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 9;
	localparam logic [CFG_IW-1:0] REG_NUM_ROWS  = 3'd0;
	localparam logic [CFG_IW-1:0] REG_NUM_COLS  = 3'd1;
	localparam logic [CFG_IW-1:0] REG_DEPTH     = 3'd2;
	localparam logic [CFG_IW-1:0] REG_FUSE_BIAS = 3'd3;
	localparam logic [CFG_IW-1:0] REG_FUSE_RELU = 3'd4;

	// Binary32 constants.
	localparam logic [31:0] FP_ONE    = 32'h3F80_0000;
	localparam logic [31:0] FP_ZERO   = 32'h0000_0000;
	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
	localparam logic [30:0] FP_INF    = 31'h7F80_0000;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  row_index;
		logic [7:0]  col_index;
		logic [31:0] value;
	} item_t;

	typedef struct packed {
		logic [5:0]  out_row;
		logic [5:0]  out_col;
		logic [31:0] out_value;
	} result_t;

	// Status of the multiply-add unit.
	typedef struct packed {
		logic busy;
		logic done;
	} fma_stat_t;

endpackage

`default_nettype wire

FILE: design/sgemm_bias_relu_top.sv
// Single-precision matrix engine with fused bias and ReLU: top level.
// Depends on sbr_pkg, sbr_fma and sgemm_bias_relu_top_assert.svh.
//
// Usage: an item is taken when start is high and busy is low. Load items
// (A element, B element, bias) are written into on-chip memories at that
// edge; busy stays low. An emit item for an output row and column that
// lies inside num_rows and num_cols raises busy and walks k = 0 .. depth-1
// (depth capped at MAX_DEPTH) through one shared iterative multiply-add
// unit; an emit outside that range gives no result.
// Each step of k goes through a memory read state, an issue state and the
// multiply-add unit, whose shortcuts for special operands and zero sums
// and whose normalize loop make its run time vary.
// The result is shown on result for one cycle marked by done; the receiver
// takes it then and cannot hold it off. busy falls with done.
// Configuration writes use cfg_valid, cfg_ready (always high), cfg_index and
// cfg_data; the user must make them only while the block is idle (unenforced).
// Reset clears the sequencer and restores the registers to 64 rows, 64
// columns, depth 256, bias and ReLU off. The memories are not cleared.
`default_nettype none

`include "sgemm_bias_relu_top_assert.svh"

module sgemm_bias_relu_top #(
	parameter int MAX_ROWS  = 64,
	parameter int MAX_COLS  = 64,
	parameter int MAX_DEPTH = 256
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire sbr_pkg::item_t              item,
	output logic                             done,
	output sbr_pkg::result_t                 result,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [sbr_pkg::CFG_IW-1:0]  cfg_index,
	input  wire logic [sbr_pkg::CFG_DW-1:0]  cfg_data
);
	import sbr_pkg::*;

	localparam int A_DEPTH = MAX_ROWS * MAX_DEPTH;
	localparam int B_DEPTH = MAX_DEPTH * MAX_COLS;
	localparam int AAW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
	localparam int BAW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int DAW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int KCW = $clog2(MAX_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_GO, S_WAIT, S_POST, S_BWAIT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [6:0] num_rows_q, num_cols_q;
	logic [8:0] depth_q;
	logic       fuse_bias_q, fuse_relu_q;

	// Emit context.
	logic [RW-1:0]  row_q;
	logic [CW-1:0]  col_q;
	logic [5:0]     out_row_q, out_col_q;
	logic [KCW-1:0] k_q, kmax_q;
	logic [31:0]    acc_q;
	logic           done_q;
	result_t        result_q;

	// Memories and their registered read data.
	logic [31:0] a_mem [A_DEPTH];
	logic [31:0] b_mem [B_DEPTH];
	logic [31:0] bias_mem [MAX_ROWS];
	logic [31:0] a_rdata_q, b_rdata_q, bias_rdata_q;

	// Multiply-add unit.
	logic        fma_go;
	logic [31:0] fma_a, fma_b, fma_res;
	fma_stat_t   fma_stat;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	// Item decode.
	logic accept, we_a, we_b, we_bias, emit_ok;
	logic [AAW-1:0] a_waddr, a_raddr;
	logic [BAW-1:0] b_waddr, b_raddr;
	logic [KCW-1:0] kmax_new;

	always_comb begin
		accept  = start && !busy;
		we_a    = accept && (item.cmd == CMD_LOAD_A) &&
			(32'(item.row_index) < MAX_ROWS) && (32'(item.col_index) < MAX_DEPTH);
		we_b    = accept && (item.cmd == CMD_LOAD_B) &&
			(32'(item.row_index) < MAX_DEPTH) && (32'(item.col_index) < MAX_COLS);
		we_bias = accept && (item.cmd == CMD_LOAD_BIAS) && (32'(item.row_index) < MAX_ROWS);
		emit_ok = accept && (item.cmd == CMD_EMIT) &&
			(32'(item.row_index) < 32'(num_rows_q)) && (32'(item.row_index) < MAX_ROWS) &&
			(32'(item.col_index) < 32'(num_cols_q)) && (32'(item.col_index) < MAX_COLS);
		a_waddr = AAW'(32'(item.row_index) * MAX_DEPTH + 32'(item.col_index));
		b_waddr = BAW'(32'(item.row_index) * MAX_COLS + 32'(item.col_index));
		a_raddr = AAW'(32'(row_q) * MAX_DEPTH + 32'(k_q[DAW-1:0]));
		b_raddr = BAW'(32'(k_q[DAW-1:0]) * MAX_COLS + 32'(col_q));
		kmax_new = (32'(depth_q) > MAX_DEPTH) ? KCW'(MAX_DEPTH) : KCW'(depth_q);
	end

	// Memory ports: one write from load items, one registered read.
	// Loads are taken only while idle, so no write comes during a walk.
	always_ff @(posedge clk) begin
		if (we_a) begin
			a_mem[a_waddr] <= item.value;
		end
		a_rdata_q <= a_mem[a_raddr];
	end

	always_ff @(posedge clk) begin
		if (we_b) begin
			b_mem[b_waddr] <= item.value;
		end
		b_rdata_q <= b_mem[b_raddr];
	end

	always_ff @(posedge clk) begin
		if (we_bias) begin
			bias_mem[RW'(item.row_index)] <= item.value;
		end
		bias_rdata_q <= bias_mem[row_q];
	end

	// Operand selection: products during the walk, bias times one at the end.
	always_comb begin
		fma_go = (state_q == S_GO) || ((state_q == S_POST) && fuse_bias_q);
		fma_a  = (state_q == S_GO) ? a_rdata_q : bias_rdata_q;
		fma_b  = (state_q == S_GO) ? b_rdata_q : FP_ONE;
	end

	sbr_fma u_fma (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (fma_go),
		.a      (fma_a),
		.b      (fma_b),
		.c      (acc_q),
		.stat   (fma_stat),
		.res    (fma_res)
	);

	// ReLU and NaN canonicalization of the finished value.
	logic [31:0] fin_in, fin_val;
	logic        fin_nan, fin_pos;

	always_comb begin
		fin_in  = (state_q == S_BWAIT) ? fma_res : acc_q;
		fin_nan = (fin_in[30:23] == 8'hFF) && (fin_in[22:0] != 23'd0);
		fin_pos = !fin_in[31] && (fin_in[30:0] != 31'd0) && !fin_nan;
		if (fuse_relu_q && !fin_pos) begin
			fin_val = FP_ZERO;
		end else if (fin_nan) begin
			fin_val = CANON_NAN;
		end else begin
			fin_val = fin_in;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q  <= 7'd64;
			num_cols_q  <= 7'd64;
			depth_q     <= 9'd256;
			fuse_bias_q <= 1'b0;
			fuse_relu_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_NUM_ROWS:  num_rows_q  <= cfg_data[6:0];
				REG_NUM_COLS:  num_cols_q  <= cfg_data[6:0];
				REG_DEPTH:     depth_q     <= cfg_data;
				REG_FUSE_BIAS: fuse_bias_q <= cfg_data[0];
				REG_FUSE_RELU: fuse_relu_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Emit sequencer with registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (emit_ok) begin
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= (kmax_q == '0) ? S_POST : S_GO;
				S_GO:   state_q <= S_WAIT;
				S_WAIT: begin
					if (fma_stat.done) begin
						state_q <= (k_q + KCW'(1) == kmax_q) ? S_POST : S_READ;
					end
				end
				S_POST: begin
					if (fuse_bias_q) begin
						state_q <= S_BWAIT;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_BWAIT: begin
					if (fma_stat.done) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Emit context and accumulator.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (emit_ok) begin
					row_q     <= RW'(item.row_index);
					col_q     <= CW'(item.col_index);
					out_row_q <= item.row_index[5:0];
					out_col_q <= item.col_index[5:0];
					k_q       <= '0;
					kmax_q    <= kmax_new;
					acc_q     <= FP_ZERO;
				end
			end
			S_WAIT: begin
				if (fma_stat.done) begin
					acc_q <= fma_res;
					k_q   <= k_q + KCW'(1);
				end
			end
			S_POST: begin
				if (!fuse_bias_q) begin
					result_q <= '{out_row: out_row_q, out_col: out_col_q, out_value: fin_val};
				end
			end
			S_BWAIT: begin
				if (fma_stat.done) begin
					result_q <= '{out_row: out_row_q, out_col: out_col_q, out_value: fin_val};
				end
			end
			default: ;
		endcase
	end

	// Checks on the sequencer.
	`SBR_ASSERT_NEXT(a_done_single, done, !done, "done strobe lasted more than one cycle")
	`SBR_ASSERT_NEXT(a_load_no_busy, start && !busy && (item.cmd != CMD_EMIT), !busy,
		"load item made the block busy")
	`SBR_ASSERT_NOW(a_go_idle_unit, fma_go, !fma_stat.busy,
		"multiply-add issued while the unit was busy")
	`SBR_ASSERT_NOW(a_k_in_range, state_q == S_WAIT, k_q < kmax_q,
		"depth counter ran past the depth in use")

endmodule

`default_nettype wire

FILE: design/sbr_fma.sv
// Iterative binary32 fused multiply-add, round to nearest even, no flushing.
// Depends on sbr_pkg.
`default_nettype none

module sbr_fma (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire logic [31:0]       a,
	input  wire logic [31:0]       b,
	input  wire logic [31:0]       c,
	output sbr_pkg::fma_stat_t     stat,
	output logic [31:0]            res
);
	import sbr_pkg::*;

	typedef enum logic [3:0] {
		F_IDLE, F_UNPK, F_ALIGN, F_ADD, F_ABS, F_NORM, F_FINE, F_RND, F_PACK
	} fstate_t;

	fstate_t state_q;
	logic        done_q;
	logic [31:0] res_q;
	logic [31:0] a_q, b_q, c_q;

	// Unpacked operands.
	logic [47:0]        mp_q;
	logic [23:0]        mc_q;
	logic signed [11:0] ep_q, ec_q;
	logic               sp_q, sc_q;

	// Aligned operands and sum.
	logic [127:0]       x_q, y_q;
	logic signed [11:0] eb_q;
	logic               sx_q, sub_q, zsign_q;
	logic [128:0]       sum_q;
	logic [127:0]       n_q;
	logic [7:0]         lz_q;
	logic               s_q;

	// Rounding inputs.
	logic [23:0]        keep_q;
	logic               guard_q, sticky_q;
	logic signed [11:0] epk_q;

	function automatic logic [4:0] clz16(input logic [15:0] v);
		logic [4:0] n;
		logic       hit;
		n = 5'd16;
		hit = 1'b0;
		for (int i = 15; i >= 0; i--) begin
			if (!hit && v[i]) begin
				n = 5'(15 - i);
				hit = 1'b1;
			end
		end
		return n;
	endfunction

	// Unpack and multiply.
	logic [7:0]         a_exp, b_exp, c_exp;
	logic               a_zero, b_zero, a_inf, b_inf, c_inf, a_nan, b_nan, c_nan;
	logic [23:0]        ma, mb, mc;
	logic signed [11:0] ea, eb, ec;
	logic               sp, p_inf, nan_r, spec;
	logic [31:0]        spec_val;

	always_comb begin
		a_exp  = a_q[30:23];
		b_exp  = b_q[30:23];
		c_exp  = c_q[30:23];
		a_zero = (a_q[30:0] == 31'd0);
		b_zero = (b_q[30:0] == 31'd0);
		a_inf  = (a_exp == 8'hFF) && (a_q[22:0] == 23'd0);
		b_inf  = (b_exp == 8'hFF) && (b_q[22:0] == 23'd0);
		c_inf  = (c_exp == 8'hFF) && (c_q[22:0] == 23'd0);
		a_nan  = (a_exp == 8'hFF) && (a_q[22:0] != 23'd0);
		b_nan  = (b_exp == 8'hFF) && (b_q[22:0] != 23'd0);
		c_nan  = (c_exp == 8'hFF) && (c_q[22:0] != 23'd0);
		ma = {a_exp != 8'd0, a_q[22:0]};
		mb = {b_exp != 8'd0, b_q[22:0]};
		mc = {c_exp != 8'd0, c_q[22:0]};
		ea = (a_exp == 8'd0) ? -12'sd149 : $signed({4'b0, a_exp}) - 12'sd150;
		eb = (b_exp == 8'd0) ? -12'sd149 : $signed({4'b0, b_exp}) - 12'sd150;
		ec = (c_exp == 8'd0) ? -12'sd149 : $signed({4'b0, c_exp}) - 12'sd150;
		sp = a_q[31] ^ b_q[31];
		p_inf = a_inf || b_inf;
		nan_r = a_nan || b_nan || c_nan || (a_inf && b_zero) || (b_inf && a_zero) ||
			(p_inf && c_inf && (sp != c_q[31]));
		spec = nan_r || p_inf || c_inf;
		if (nan_r) begin
			spec_val = CANON_NAN;
		end else if (p_inf) begin
			spec_val = {sp, FP_INF};
		end else begin
			spec_val = c_q;
		end
	end

	// Alignment: the operand with the larger exponent moves left by at most 76.
	logic               swap;
	logic [47:0]        mx, my, ymag;
	logic signed [11:0] ex, ey, d, ebase;
	logic               sx, sy;
	logic [6:0]         sh;

	always_comb begin
		swap  = (mp_q == 48'd0) || ((mc_q != 24'd0) && (ec_q > ep_q));
		mx    = swap ? {24'd0, mc_q} : mp_q;
		my    = swap ? mp_q : {24'd0, mc_q};
		ex    = swap ? ec_q : ep_q;
		ey    = swap ? ep_q : ec_q;
		sx    = swap ? sc_q : sp_q;
		sy    = swap ? sp_q : sc_q;
		d     = ex - ey;
		if (my == 48'd0) begin
			sh   = 7'd0;
			ymag = 48'd0;
		end else if (d > 12'sd76) begin
			// The smaller operand only affects the sticky bit.
			sh   = 7'd76;
			ymag = 48'd1;
		end else begin
			sh   = 7'(d);
			ymag = my;
		end
		ebase = ex - $signed({5'b0, sh});
	end

	// Rounding position and guard and sticky bits.
	logic signed [11:0] ebn, tmin, t, tm1, epk;
	logic [127:0]       shv;
	logic [23:0]        keep;
	logic               guard, sticky;

	always_comb begin
		ebn  = eb_q - $signed({4'b0, lz_q});
		tmin = -12'sd149 - ebn;
		t    = (tmin > 12'sd104) ? tmin : 12'sd104;
		tm1  = t - 12'sd1;
		epk  = ebn + t + 12'sd149;
		shv  = n_q >> tm1[6:0];
		if (tm1 >= 12'sd128) begin
			keep   = 24'd0;
			guard  = 1'b0;
			sticky = 1'b1;
		end else begin
			keep   = shv[24:1];
			guard  = shv[0];
			sticky = |(n_q & ((128'd1 << tm1[6:0]) - 128'd1));
		end
	end

	// Final packing; a rounding carry moves into the exponent by itself.
	logic        up;
	logic [31:0] mag;

	always_comb begin
		up  = guard_q && (sticky_q || keep_q[0]);
		mag = {1'b0, epk_q[7:0], 23'd0} + {8'd0, keep_q} + {31'd0, up};
	end

	// Sequencer of the unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				F_IDLE: begin
					if (go) begin
						state_q <= F_UNPK;
					end
				end
				F_UNPK: begin
					if (spec) begin
						done_q  <= 1'b1;
						state_q <= F_IDLE;
					end else begin
						state_q <= F_ALIGN;
					end
				end
				F_ALIGN: state_q <= F_ADD;
				F_ADD:   state_q <= F_ABS;
				F_ABS: begin
					if (sum_q == 129'd0) begin
						done_q  <= 1'b1;
						state_q <= F_IDLE;
					end else begin
						state_q <= F_NORM;
					end
				end
				F_NORM: begin
					if (n_q[127:112] != 16'd0) begin
						state_q <= F_FINE;
					end
				end
				F_FINE: state_q <= F_RND;
				F_RND:  state_q <= F_PACK;
				F_PACK: begin
					done_q  <= 1'b1;
					state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (go) begin
					a_q <= a;
					b_q <= b;
					c_q <= c;
				end
			end
			F_UNPK: begin
				mp_q <= ma * mb;
				ep_q <= ea + eb;
				mc_q <= mc;
				ec_q <= ec;
				sp_q <= sp;
				sc_q <= c_q[31];
				res_q <= spec_val;
			end
			F_ALIGN: begin
				x_q     <= 128'(mx) << sh;
				y_q     <= 128'(ymag);
				eb_q    <= ebase;
				sx_q    <= sx;
				sub_q   <= sx ^ sy;
				zsign_q <= (mp_q == 48'd0) && (mc_q == 24'd0) && sp_q && sc_q;
			end
			F_ADD: begin
				sum_q <= sub_q ? ({1'b0, x_q} - {1'b0, y_q}) : ({1'b0, x_q} + {1'b0, y_q});
			end
			F_ABS: begin
				res_q <= {zsign_q, 31'd0};
				lz_q  <= 8'd0;
				if (sum_q[128]) begin
					n_q <= ~sum_q[127:0] + 128'd1;
					s_q <= ~sx_q;
				end else begin
					n_q <= sum_q[127:0];
					s_q <= sx_q;
				end
			end
			F_NORM: begin
				if (n_q[127:112] == 16'd0) begin
					n_q  <= n_q << 16;
					lz_q <= lz_q + 8'd16;
				end
			end
			F_FINE: begin
				n_q  <= n_q << clz16(n_q[127:112]);
				lz_q <= lz_q + 8'(clz16(n_q[127:112]));
			end
			F_RND: begin
				keep_q   <= keep;
				guard_q  <= guard;
				sticky_q <= sticky;
				epk_q    <= epk;
			end
			F_PACK: begin
				if (epk_q >= 12'sd254) begin
					res_q <= {s_q, FP_INF};
				end else begin
					res_q <= {s_q, mag[30:0]};
				end
			end
			default: ;
		endcase
	end

	assign stat.busy = (state_q != F_IDLE);
	assign stat.done = done_q;
	assign res       = res_q;

endmodule

`default_nettype wire
